// File: rtl/core/m3inv_pkg.sv
// m3inv_pkg: widths, queue and divider stage types, cofactor operand table
// for the 3x3 matrix inverse core. No dependencies.

package m3inv_pkg;

  localparam int unsigned EW       = 16;            // entry width, signed
  localparam int unsigned EF       = 14;            // entry fraction bits
  localparam int unsigned RW       = 32;            // result width, signed
  localparam int unsigned RF       = 16;            // result fraction bits
  localparam int unsigned NE       = 9;             // entries per matrix
  localparam int unsigned PW       = 2 * EW;        // entry product
  localparam int unsigned CW       = PW + 1;        // signed cofactor
  localparam int unsigned MW       = PW;            // cofactor magnitude
  localparam int unsigned TW       = EW + CW;       // entry times cofactor
  localparam int unsigned DETW     = TW + 2;        // sum of three terms
  localparam int unsigned DW       = TW - 1;        // determinant magnitude
  localparam int unsigned STEPS    = RW;            // quotient bits per entry
  localparam int unsigned PRE_SHIFT = RW - EF - RF; // numerator bits below the start

  // operand indices a*b - c*d per adjugate entry, row-major
  localparam int unsigned COF_IDX [NE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic [NE-1:0][MW-1:0] mag;
    logic [NE-1:0]         neg;
    logic [DW-1:0]         dmag;
    logic                  sing;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [NE-1:0][DW-1:0]        rem;
    logic [NE-1:0][RW-1:0]        quo;
    logic [NE-1:0][PRE_SHIFT-1:0] low;
    logic [NE-1:0]                neg;
    logic [NE-1:0]                ovf;
    logic [DW-1:0]                dmag;
    logic                         sing;
  } div_t;

endpackage

// File: rtl/core/m3inv_if.sv
// m3inv_in_if / m3inv_out_if: valid/ready channels of the matrix inverse core
// depends on m3inv_pkg

interface m3inv_in_if;
  logic valid;
  logic ready;
  logic signed [m3inv_pkg::EW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface m3inv_out_if;
  logic valid;
  logic ready;
  logic signed [m3inv_pkg::RW-1:0] inv00, inv01, inv02, inv10, inv11, inv12;
  logic signed [m3inv_pkg::RW-1:0] inv20, inv21, inv22;
  logic singular;
  logic saturated;
  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                  inv21, inv22, singular, saturated, input ready);
  modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20,
                inv21, inv22, singular, saturated, output ready);
endinterface

// File: rtl/core/m3inv_front.sv
// m3inv_front: cofactors and determinant in three stages, then classification
// into magnitudes, signs and singular flag for the queue. depends on m3inv_pkg, m3inv_if

module m3inv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  m3inv_in_if.sink            in_i,
  input  m3inv_pkg::q_stat_t  stat_i,
  output m3inv_pkg::push_t    push_o
);

  logic signed [m3inv_pkg::EW-1:0] a [m3inv_pkg::NE];
  logic signed [m3inv_pkg::PW-1:0] prod_q [m3inv_pkg::NE][2];
  logic signed [m3inv_pkg::EW-1:0] r0a_q [3];
  logic signed [m3inv_pkg::EW-1:0] r0b_q [3];
  logic signed [m3inv_pkg::CW-1:0] cof_q [m3inv_pkg::NE];
  logic signed [m3inv_pkg::CW-1:0] cof3_q [m3inv_pkg::NE];
  logic signed [m3inv_pkg::TW-1:0] term_q [3];
  logic signed [m3inv_pkg::DETW-1:0] det;
  logic [m3inv_pkg::DETW-1:0] det_abs;
  logic v1_q, v2_q, v3_q;
  logic en;

  assign a[0] = in_i.m00;
  assign a[1] = in_i.m01;
  assign a[2] = in_i.m02;
  assign a[3] = in_i.m10;
  assign a[4] = in_i.m11;
  assign a[5] = in_i.m12;
  assign a[6] = in_i.m20;
  assign a[7] = in_i.m21;
  assign a[8] = in_i.m22;

  // the whole front holds only when its last item cannot enter the queue
  assign en         = !(v3_q && stat_i.full);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  for (genvar i = 0; i < m3inv_pkg::NE; i++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[i][0] <= a[m3inv_pkg::COF_IDX[i][0]] * a[m3inv_pkg::COF_IDX[i][1]];
        prod_q[i][1] <= a[m3inv_pkg::COF_IDX[i][2]] * a[m3inv_pkg::COF_IDX[i][3]];
        cof_q[i]     <= m3inv_pkg::CW'(prod_q[i][0]) - m3inv_pkg::CW'(prod_q[i][1]);
        cof3_q[i]    <= cof_q[i];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk_i) begin
      if (en) begin
        r0a_q[j]  <= a[j];
        r0b_q[j]  <= r0a_q[j];
        // row 0 entry times the matching column-0 adjugate entry
        term_q[j] <= m3inv_pkg::TW'(r0b_q[j]) * m3inv_pkg::TW'(cof_q[3*j]);
      end
    end
  end

  always_comb begin
    det = m3inv_pkg::DETW'(term_q[0]) + m3inv_pkg::DETW'(term_q[1])
        + m3inv_pkg::DETW'(term_q[2]);
    det_abs = det[m3inv_pkg::DETW-1] ? m3inv_pkg::DETW'(-det) : m3inv_pkg::DETW'(det);
    push_o.valid      = v3_q;
    push_o.entry.sing = (det == '0);
    push_o.entry.dmag = det_abs[m3inv_pkg::DW-1:0];
    for (int i = 0; i < m3inv_pkg::NE; i++) begin
      logic [m3inv_pkg::CW-1:0] cabs;
      cabs = cof3_q[i][m3inv_pkg::CW-1] ? m3inv_pkg::CW'(-cof3_q[i])
                                        : m3inv_pkg::CW'(cof3_q[i]);
      push_o.entry.mag[i] = cabs[m3inv_pkg::MW-1:0];
      push_o.entry.neg[i] = (cof3_q[i][m3inv_pkg::CW-1] != det[m3inv_pkg::DETW-1])
                            && (cof3_q[i] != '0);
    end
  end

endmodule

// File: rtl/core/m3inv_queue.sv
// m3inv_queue: two-entry queue between the classifying front and the divider
// back end. depends on m3inv_pkg

module m3inv_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  m3inv_pkg::push_t     push_i,
  input  logic                 pop_i,
  output m3inv_pkg::q_stat_t   stat_o,
  output m3inv_pkg::q_entry_t  head_o
);

  m3inv_pkg::q_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign push   = push_i.valid && !stat_o.full;
  assign pop    = pop_i && !stat_o.empty;
  assign head_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// File: rtl/core/m3inv_back.sv
// m3inv_back: nine-lane pipelined restoring divider, one quotient bit per
// stage, then saturation and the output register. depends on m3inv_pkg, m3inv_if

module m3inv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  m3inv_pkg::q_stat_t   stat_i,
  input  m3inv_pkg::q_entry_t  head_i,
  output logic                 pop_o,
  m3inv_out_if.source          out_o
);

  m3inv_pkg::div_t st_q [m3inv_pkg::STEPS+1];
  m3inv_pkg::div_t st0;
  logic [m3inv_pkg::STEPS:0] v_q;
  logic en;
  logic ov_q;
  logic [m3inv_pkg::NE-1:0][m3inv_pkg::RW-1:0] res;
  logic [m3inv_pkg::NE-1:0] sat;
  logic [m3inv_pkg::NE-1:0][m3inv_pkg::RW-1:0] res_q;
  logic sing_q, satf_q;

  assign en    = !ov_q || out_o.ready;
  assign pop_o = en && !stat_i.empty;

  // first stage: quotient of 2^RW or more saturates, else start from the top bits
  always_comb begin
    st0.dmag = head_i.dmag;
    st0.sing = head_i.sing;
    st0.neg  = head_i.neg;
    st0.quo  = '0;
    for (int i = 0; i < m3inv_pkg::NE; i++) begin
      logic [m3inv_pkg::MW-1:0] top;
      top = head_i.mag[i] >> m3inv_pkg::PRE_SHIFT;
      st0.ovf[i] = (m3inv_pkg::DW'(top) >= head_i.dmag);
      st0.rem[i] = st0.ovf[i] ? '0 : m3inv_pkg::DW'(top);
      st0.low[i] = head_i.mag[i][m3inv_pkg::PRE_SHIFT-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q  <= {v_q[m3inv_pkg::STEPS-1:0], !stat_i.empty};
      ov_q <= v_q[m3inv_pkg::STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st0;
    end
  end

  for (genvar k = 1; k <= m3inv_pkg::STEPS; k++) begin : g_step
    m3inv_pkg::div_t nx;
    always_comb begin
      nx = st_q[k-1];
      for (int i = 0; i < m3inv_pkg::NE; i++) begin
        logic [m3inv_pkg::DW:0] r2;
        logic nb;
        logic ge;
        if (k <= m3inv_pkg::PRE_SHIFT) begin
          nb = st_q[k-1].low[i][(m3inv_pkg::PRE_SHIFT - k) % m3inv_pkg::PRE_SHIFT];
        end else begin
          nb = 1'b0;
        end
        r2 = {st_q[k-1].rem[i], nb};
        ge = (r2 >= {1'b0, st_q[k-1].dmag});
        nx.rem[i] = ge ? m3inv_pkg::DW'(r2 - {1'b0, st_q[k-1].dmag})
                       : r2[m3inv_pkg::DW-1:0];
        nx.quo[i] = {st_q[k-1].quo[i][m3inv_pkg::RW-2:0], ge};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= nx;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < m3inv_pkg::NE; i++) begin
      logic [m3inv_pkg::RW-1:0] q;
      q = st_q[m3inv_pkg::STEPS].quo[i];
      if (st_q[m3inv_pkg::STEPS].sing) begin
        res[i] = '0;
        sat[i] = 1'b0;
      end else if (st_q[m3inv_pkg::STEPS].neg[i]) begin
        sat[i] = st_q[m3inv_pkg::STEPS].ovf[i]
                 || (q[m3inv_pkg::RW-1] && (q[m3inv_pkg::RW-2:0] != '0));
        res[i] = sat[i] ? {1'b1, {(m3inv_pkg::RW-1){1'b0}}} : m3inv_pkg::RW'(-q);
      end else begin
        sat[i] = st_q[m3inv_pkg::STEPS].ovf[i] || q[m3inv_pkg::RW-1];
        res[i] = sat[i] ? {1'b0, {(m3inv_pkg::RW-1){1'b1}}} : q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res;
      sing_q <= st_q[m3inv_pkg::STEPS].sing;
      satf_q <= |sat;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.inv00     = res_q[0];
  assign out_o.inv01     = res_q[1];
  assign out_o.inv02     = res_q[2];
  assign out_o.inv10     = res_q[3];
  assign out_o.inv11     = res_q[4];
  assign out_o.inv12     = res_q[5];
  assign out_o.inv20     = res_q[6];
  assign out_o.inv21     = res_q[7];
  assign out_o.inv22     = res_q[8];
  assign out_o.singular  = sing_q;
  assign out_o.saturated = satf_q;

endmodule

// File: rtl/core/matrix3x3_inverse_core.sv
// matrix3x3_inverse_core: 3x3 inverse by adjugate over determinant, Q2.14 in, Q16.16 out
// depends on m3inv_pkg, m3inv_if, m3inv_front, m3inv_queue, m3inv_back
//
//   port   | dir | payload                               | handshake
//   in_i   | in  | m00..m22, 16-bit signed Q2.14          | valid/ready
//   out_o  | out | inv00..inv22 Q16.16, singular, saturated | valid/ready
//
// one matrix per cycle sustained while out_o is not stalled; the path runs through
// the front stages, the queue register, 33 divider stages (an overflow check, then
// one quotient bit per stage) and the output register.
// reset clears all valid flags and the queue counters; no clearing pass.
// a stalled output freezes the divider; the queue then absorbs two items
// before the front stalls and in_i.ready falls.

module matrix3x3_inverse_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3inv_in_if.sink     in_i,
  m3inv_out_if.source  out_o
);

  m3inv_pkg::push_t    push;
  m3inv_pkg::q_stat_t  stat;
  m3inv_pkg::q_entry_t head;
  logic                pop;

  m3inv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push)
  );

  m3inv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (stat),
    .head_o (head)
  );

  m3inv_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// File: rtl/core/m3inv_checker.sv
// m3inv_checker: port-level checks on the inverse core result channel
// depends on m3inv_pkg; bound to matrix3x3_inverse_core

module m3inv_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    valid_i,
  input logic                    ready_i,
  input logic                    singular_i,
  input logic                    saturated_i,
  input logic [m3inv_pkg::RW-1:0] e0_i, e1_i, e2_i, e3_i, e4_i, e5_i, e6_i, e7_i, e8_i
);

  logic [m3inv_pkg::RW-1:0] maxv, minv;
  logic any_zero_ne, any_clip;

  assign maxv = {1'b0, {(m3inv_pkg::RW-1){1'b1}}};
  assign minv = {1'b1, {(m3inv_pkg::RW-1){1'b0}}};
  assign any_zero_ne = (e0_i != '0) || (e1_i != '0) || (e2_i != '0) || (e3_i != '0)
                    || (e4_i != '0) || (e5_i != '0) || (e6_i != '0) || (e7_i != '0)
                    || (e8_i != '0);
  assign any_clip = (e0_i == maxv) || (e0_i == minv) || (e1_i == maxv) || (e1_i == minv)
                 || (e2_i == maxv) || (e2_i == minv) || (e3_i == maxv) || (e3_i == minv)
                 || (e4_i == maxv) || (e4_i == minv) || (e5_i == maxv) || (e5_i == minv)
                 || (e6_i == maxv) || (e6_i == minv) || (e7_i == maxv) || (e7_i == minv)
                 || (e8_i == maxv) || (e8_i == minv);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result item dropped while stalled");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && singular_i |-> !any_zero_ne)
    else $error("singular item with nonzero entries");

  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && singular_i |-> !saturated_i)
    else $error("singular item flagged saturated");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && saturated_i |-> any_clip)
    else $error("saturated item with no clipped entry");

endmodule

bind matrix3x3_inverse_core m3inv_checker u_m3inv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (out_o.valid),
  .ready_i     (out_o.ready),
  .singular_i  (out_o.singular),
  .saturated_i (out_o.saturated),
  .e0_i        (out_o.inv00),
  .e1_i        (out_o.inv01),
  .e2_i        (out_o.inv02),
  .e3_i        (out_o.inv10),
  .e4_i        (out_o.inv11),
  .e5_i        (out_o.inv12),
  .e6_i        (out_o.inv20),
  .e7_i        (out_o.inv21),
  .e8_i        (out_o.inv22)
);
